>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL of the correlating branch predictor.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, masked while reset is asserted
`define CBP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cbp assertion failed");

// Clocked check, also active during reset
`define CBP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cbp assertion failed");

`else

`define CBP_ASSERT(lbl, clk, rstn, prop)
`define CBP_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> hdl/cbp_pkg.sv
// Package for the correlating branch predictor: fixed widths, register
// indexes, reset values and the 2-bit counter update. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cbp_pkg;

  localparam int ADDR_W     = 32;  // branch address width
  localparam int CNT_W      = 32;  // running totals width
  localparam int CTR_W      = 2;   // pattern counter width
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int M_REG_W    = 4;   // address_index_bits register
  localparam int K_REG_W    = 3;   // history_length register

  typedef logic [CTR_W-1:0] ctr_t;

  localparam ctr_t CTR_INIT = 2'd3;  // strongly taken
  localparam ctr_t CTR_MAX  = 2'd3;
  localparam ctr_t CTR_MIN  = 2'd0;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIST_LEN  = 2'd1;

  localparam logic [M_REG_W-1:0] M_RESET = 4'd10;
  localparam logic [K_REG_W-1:0] K_RESET = 3'd2;

  // Saturating step toward the outcome
  function automatic ctr_t ctr_step(input ctr_t ctr, input logic taken);
    ctr_t res;
    res = ctr;
    if (taken) begin
      if (ctr != CTR_MAX) res = ctr + ctr_t'(1);
    end else begin
      if (ctr != CTR_MIN) res = ctr - ctr_t'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hdl/cbp_pht.sv
// Pattern history table: single-port-write, registered-read counter memory
// with a clearing sweep after reset. Depends on cbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbp_pht #(
  parameter int IDX_W = 14
) (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic rd_en,
  input  wire                logic [IDX_W-1:0] rd_addr,
  output cbp_pkg::ctr_t      rd_data,
  input  wire                logic wr_en,
  input  wire                logic [IDX_W-1:0] wr_addr,
  input  wire cbp_pkg::ctr_t wr_data,
  output logic               clr_busy
);
  import cbp_pkg::*;

  localparam int DEPTH = 1 << IDX_W;

  ctr_t             mem [DEPTH];
  ctr_t             rd_data_r;
  logic             clr_busy_r;
  logic [IDX_W-1:0] clr_addr_r;

  // Clearing sweep: one entry per cycle from reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + IDX_W'(1);
      if (clr_addr_r == {IDX_W{1'b1}}) clr_busy_r <= 1'b0;
    end
  end

  // Write port, shared by the sweep and the update path
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= CTR_INIT;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; returns the old value on a same-cycle write
  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

`default_nettype wire

>>> hdl/correlating_branch_predictor_core.sv
// Top level of the (m,k) correlating branch predictor with 2-bit counters.
// Depends on cbp_pkg, cbp_pht and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// One resolved branch is accepted per cycle and its result passes the table read,
// then the update stage and output register; a result waiting on
// out_ready stalls the input only once the update stage is also occupied.
// Rate is set by the registered read and write-back of the pattern table,
// with the new counter forwarded when consecutive branches hit the same entry.
// After reset the table is swept to "strongly taken", one entry per cycle over
// all 2^(MAX_ADDR_BITS+MAX_HIST_BITS) entries (16384 with the defaults), during
// which in_ready stays low; configuration writes are taken at any time.
module correlating_branch_predictor_core #(
  parameter int MAX_ADDR_BITS = 10,
  parameter int MAX_HIST_BITS = 4
) (
  input  wire  logic clk,
  input  wire  logic rst_n,
  // configuration
  input  wire  logic cfg_valid,
  output logic       cfg_ready,
  input  wire  logic [cbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  logic [cbp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // resolved branches
  input  wire  logic in_valid,
  output logic       in_ready,
  input  wire  logic [cbp_pkg::ADDR_W-1:0] in_branch_address,
  input  wire  logic in_taken,
  // results
  output logic       out_valid,
  input  wire  logic out_ready,
  output logic       out_predicted_taken,
  output logic       out_mispredicted,
  output logic [cbp_pkg::CNT_W-1:0] out_mispredict_total,
  output logic [cbp_pkg::CNT_W-1:0] out_branch_total
);
  import cbp_pkg::*;

  localparam int IDX_W = MAX_ADDR_BITS + MAX_HIST_BITS;
  localparam int KW    = $clog2(MAX_HIST_BITS + 1);

  // Configuration registers
  logic [M_REG_W-1:0] m_r;
  logic [K_REG_W-1:0] k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= M_RESET;
      k_r <= K_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ADDR_BITS: m_r <= cfg_wdata[M_REG_W-1:0];
        REG_HIST_LEN:  k_r <= cfg_wdata[K_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Pipeline control
  logic hist_unused;
  logic [MAX_HIST_BITS-1:0] hist_r;
  logic s1_valid_r, s1_taken_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic fwd_hit_r;
  ctr_t fwd_ctr_r;
  logic out_valid_r, out_pred_r, out_miss_r;
  logic [CNT_W-1:0] mcnt_r, bcnt_r;
  logic clr_busy, s1_adv, in_xfer;
  ctr_t rd_data, ctr_cur, ctr_new;
  logic pred, miss;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clr_busy && (!s1_valid_r || s1_adv);
  assign in_xfer  = in_valid && in_ready;

  // Index: row from low address bits, column from the newest k history bits
  logic [MAX_ADDR_BITS-1:0] row_mask;
  logic [KW-1:0]            k_sat, col_shift;
  logic [MAX_HIST_BITS-1:0] col;
  logic [IDX_W-1:0]         idx;

  always_comb begin
    for (int i = 0; i < MAX_ADDR_BITS; i++) begin
      row_mask[i] = (int'(m_r) > i);
    end
    k_sat     = (int'(k_r) > MAX_HIST_BITS) ? KW'(MAX_HIST_BITS) : KW'(k_r);
    col_shift = KW'(MAX_HIST_BITS) - k_sat;
    col       = hist_r >> col_shift;
    idx       = {in_branch_address[MAX_ADDR_BITS-1:0] & row_mask, col};
  end

  assign hist_unused = 1'b0;

  // Global history: newest outcome enters at the top
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '1;
    end else if (in_xfer) begin
      hist_r <= (hist_r >> 1) |
                (MAX_HIST_BITS'(in_taken) << (MAX_HIST_BITS - 1));
    end
  end

  cbp_pht #(.IDX_W(IDX_W)) u_pht (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_xfer),
    .rd_addr  (idx),
    .rd_data  (rd_data),
    .wr_en    (s1_adv),
    .wr_addr  (s1_idx_r),
    .wr_data  (ctr_new),
    .clr_busy (clr_busy)
  );

  // Update stage: pick forwarded counter when the previous branch hit the same entry
  always_comb begin
    ctr_cur = fwd_hit_r ? fwd_ctr_r : rd_data;
    pred    = ctr_cur[CTR_W-1];
    miss    = pred ^ s1_taken_r;
    ctr_new = ctr_step(ctr_cur, s1_taken_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
        fwd_hit_r  <= s1_adv && (idx == s1_idx_r) && !hist_unused;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
        fwd_hit_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_idx_r   <= idx;
      s1_taken_r <= in_taken;
      fwd_ctr_r  <= ctr_new;
    end
  end

  // Running totals and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcnt_r      <= '0;
      bcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        mcnt_r      <= mcnt_r + CNT_W'(miss);
        bcnt_r      <= bcnt_r + CNT_W'(1);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pred_r <= pred;
      out_miss_r <= miss;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_predicted_taken  = out_pred_r;
  assign out_mispredicted     = out_miss_r;
  assign out_mispredict_total = mcnt_r;
  assign out_branch_total     = bcnt_r;

  // Checks
  `CBP_ASSERT(a_no_item_in_sweep, clk, rst_n, clr_busy |-> !s1_valid_r && !in_ready)
  `CBP_ASSERT(a_fwd_needs_item, clk, rst_n, fwd_hit_r |-> s1_valid_r)
  `CBP_ASSERT(a_adv_gives_result, clk, rst_n, s1_adv |=> out_valid_r && (bcnt_r == $past(bcnt_r) + CNT_W'(1)))
  `CBP_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid_r && !s1_valid_r)

endmodule

`default_nettype wire

>>> verif/tb.sv
// Testbench for correlating_branch_predictor_core: directed and random resolved branches
// with register changes between phases, checked against a table/history predictor kept here.
// Depends on cbp_pkg and the RTL of the core.
`timescale 1ns / 1ps

module tb;
  import cbp_pkg::*;

  localparam int PERIOD         = 12;
  localparam int TIMEOUT_CYCLES = 400000;  // sweep of 16384 entries plus slow traffic, many times over
  localparam int M_MAX          = 10;      // core defaults
  localparam int K_MAX          = 4;
  localparam int TABLE_SIZE     = 1 << (M_MAX + K_MAX);
  localparam int DRAIN_CYCLES   = 4;       // margin after the last result comes back
  localparam int PHASE_ITEMS    = 50;
  localparam int PHASES         = 9;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  typedef struct packed {
    logic              pred;
    logic              miss;
    logic [CNT_W-1:0]  miss_total;
    logic [CNT_W-1:0]  br_total;
  } branch_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [ADDR_W-1:0] in_branch_address = '0;
  logic              in_taken = 1'b0;

  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_predicted_taken;
  logic             out_mispredicted;
  logic [CNT_W-1:0] out_mispredict_total;
  logic [CNT_W-1:0] out_branch_total;

  // predictor state mirrored here
  ctr_t               pht_model [TABLE_SIZE];
  logic [K_MAX-1:0]   hist_model;
  logic [CNT_W-1:0]   miss_total_model;
  logic [CNT_W-1:0]   branch_total_model;
  logic [M_REG_W-1:0] m_setting;
  logic [K_REG_W-1:0] k_setting;

  branch_result_t pending_results [$];
  branch_result_t want_r;
  int             error_count = 0;
  int             out_hold = 0;
  bit             idle_on = 1'b1;

  correlating_branch_predictor_core u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_branch_address    (in_branch_address),
    .in_taken             (in_taken),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_predicted_taken  (out_predicted_taken),
    .out_mispredicted     (out_mispredicted),
    .out_mispredict_total (out_mispredict_total),
    .out_branch_total     (out_branch_total)
  );

  always #(PERIOD / 2) clk = ~clk;

  // Look up the counter for one branch, train it and queue the result it should give
  task automatic predict_branch(input logic [ADDR_W-1:0] addr, input logic tk);
    int m, k, row, col, idx;
    ctr_t ctr;
    branch_result_t r;
    m = (m_setting > M_MAX) ? M_MAX : int'(m_setting);
    k = (k_setting > K_MAX) ? K_MAX : int'(k_setting);
    row = int'(addr & ((32'd1 << m) - 32'd1));
    col = int'(hist_model) >> (K_MAX - k);
    idx = (row << K_MAX) | col;
    ctr = pht_model[idx];
    r.pred = ctr[1];
    r.miss = ctr[1] ^ tk;
    if (tk) begin
      if (ctr != CTR_MAX) ctr = ctr + 2'd1;
    end else begin
      if (ctr != CTR_MIN) ctr = ctr - 2'd1;
    end
    pht_model[idx] = ctr;
    hist_model = {tk, hist_model[K_MAX-1:1]};
    miss_total_model = miss_total_model + CNT_W'(r.miss);
    branch_total_model = branch_total_model + CNT_W'(1);
    r.miss_total = miss_total_model;
    r.br_total = branch_total_model;
    pending_results.push_back(r);
  endtask

  // One branch transfer; valid stays up when the next call has no gap
  task automatic send_branch(input logic [ADDR_W-1:0] addr, input logic tk);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_branch_address <= addr;
    in_taken <= tk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_branch(addr, tk);
  endtask

  // Register write; the model follows on the transfer
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_ADDR_BITS) m_setting = data;
    else if (idx == REG_HIST_LEN) k_setting = data[K_REG_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_widths(input int m, input int k);
    write_reg(REG_ADDR_BITS, CFG_DATA_W'(m));
    write_reg(REG_HIST_LEN, CFG_DATA_W'(k));
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Default widths straight out of reset, address extremes
  task automatic test_reset_defaults();
    idle_on = 1'b1;
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'h0000_03FF, 1'b1);
    send_branch(32'hFFFF_FC00, 1'b0);
    wait_drain();
  endtask

  // Zero widths: every branch hits entry 0, back to back, both saturation ends
  task automatic test_same_entry_back_to_back();
    logic [9:0] pattern;
    int i;
    pattern = 10'b10_1111_0000;
    idle_on = 1'b0;
    set_widths(0, 0);
    for (i = 0; i < 10; i++) send_branch($urandom, pattern[i]);
    wait_drain();
  endtask

  // Widths above the maximum saturate; writes to unused indexes change nothing
  task automatic test_width_limits();
    idle_on = 1'b1;
    write_reg(REG_ADDR_BITS, 4'hF);
    write_reg(REG_HIST_LEN, 4'hF);
    write_reg(REG_UNUSED_2, 4'hF);
    write_reg(REG_UNUSED_3, 4'h0);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'h0000_0400, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'h0000_0400, 1'b0);
    wait_drain();
    set_widths(0, K_MAX);
    send_branch(32'h1234_5678, 1'b0);
    send_branch(32'h8765_4321, 1'b1);
    wait_drain();
    set_widths(M_MAX, 0);
    send_branch(32'h0000_03FF, 1'b0);
    send_branch(32'h0000_07FF, 1'b0);
    wait_drain();
  endtask

  // Phases of branch traffic on a few hot addresses with biased outcomes
  task automatic test_random_traffic();
    logic [ADDR_W-1:0] hot_addr [8];
    logic              bias [8];
    logic [ADDR_W-1:0] a;
    logic              t;
    int phase, n, sel;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: set_widths(M_MAX, K_MAX);
        1: set_widths(0, 0);
        2: set_widths(15, 7);
        3: set_widths(1, 1);
        4: set_widths(3, 2);
        default: set_widths($urandom_range(0, 15), $urandom_range(0, 7));
      endcase
      if (phase == 5) write_reg(REG_UNUSED_2, CFG_DATA_W'($urandom));
      idle_on = (phase % 3 != 0);
      for (n = 0; n < 8; n++) begin
        hot_addr[n] = $urandom;
        bias[n] = 1'($urandom_range(0, 1));
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        sel = $urandom_range(0, 7);
        if ($urandom_range(0, 3) != 0) begin
          a = hot_addr[sel];
          // hot address 0 takes its outcome from the parity of the item number
          if (sel == 0) t = n[0];
          else t = ($urandom_range(0, 4) != 0) ? bias[sel] : 1'($urandom_range(0, 1));
        end else begin
          a = $urandom;
          t = 1'($urandom_range(0, 1));
        end
        send_branch(a, t);
      end
      wait_drain();
    end
  endtask

  // Result checker: compare each transfer with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no branch pending");
        error_count++;
      end else begin
        want_r = pending_results.pop_front();
        if (out_predicted_taken !== want_r.pred) begin
          $error("predicted_taken: expected %0d, got %0d", want_r.pred, out_predicted_taken);
          error_count++;
        end
        if (out_mispredicted !== want_r.miss) begin
          $error("mispredicted: expected %0d, got %0d", want_r.miss, out_mispredicted);
          error_count++;
        end
        if (out_mispredict_total !== want_r.miss_total) begin
          $error("mispredict_total: expected %0d, got %0d",
                 want_r.miss_total, out_mispredict_total);
          error_count++;
        end
        if (out_branch_total !== want_r.br_total) begin
          $error("branch_total: expected %0d, got %0d", want_r.br_total, out_branch_total);
          error_count++;
        end
      end
      out_hold = idle_on ? $urandom_range(0, 10) : 0;
    end
  end

  // Result side stalls for the drawn number of cycles after each transfer
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    for (int i = 0; i < TABLE_SIZE; i++) pht_model[i] = CTR_INIT;
    hist_model = '1;
    miss_total_model = '0;
    branch_total_model = '0;
    m_setting = M_RESET;
    k_setting = K_RESET;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_same_entry_back_to_back();
    test_width_limits();
    test_random_traffic();

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(PERIOD * TIMEOUT_CYCLES);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
